/* hdl/dmd_pkg.sv */
// ----------------------------------------------------------------------------
// dmd_pkg
// Shared widths and constants of the depth minimum downsampler.
// ----------------------------------------------------------------------------
package dmd_pkg;

  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned OUT_COL_W = 9;

  localparam logic [CFG_W-1:0]   GROUPS_RESET = CFG_W'(160);
  // Encoded form of an invalid (zero) pixel: pixel minus one, modulo 2^16.
  localparam logic [PIXEL_W-1:0] KEY_INVALID  = {PIXEL_W{1'b1}};

endpackage

/* hdl/dmd_ram.sv */
// ----------------------------------------------------------------------------
// dmd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dmd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/depth_min_downsample_4x4.sv */
// ----------------------------------------------------------------------------
// depth_min_downsample_4x4
// Streaming 4x4 minimum pooling of a depth image; zero pixels are ignored.
// ----------------------------------------------------------------------------
// A result appears on the output register in the cycle after the item that
// completes its tile is accepted.
// Throughput: one pixel per cycle while results are taken; the input stalls
// only while a finished result waits in the output register.
// Reset clears the counters and the output valid and sets the row width
// register to 160 groups. The line store is not cleared; each band's first row fills it.
module depth_min_downsample_4x4 #(
  parameter int unsigned MAX_GROUPS = 512,
  parameter int unsigned TILE_SIZE  = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dmd_pkg::PIXEL_W-1:0]   depth_pixel_i,
  input  logic                          frame_start_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dmd_pkg::PIXEL_W-1:0]   min_depth_o,
  output logic [dmd_pkg::OUT_COL_W-1:0] out_column_o,
  output logic                          row_end_o
);

  import dmd_pkg::*;

  localparam int unsigned GRP_W = $clog2(MAX_GROUPS);
  localparam int unsigned SUB_W = $clog2(TILE_SIZE);
  localparam int unsigned COL_W = $clog2(MAX_GROUPS * TILE_SIZE);
  localparam int unsigned CNT_W = $clog2(MAX_GROUPS * TILE_SIZE + 1);
  localparam int unsigned GCW   = (CFG_W > $clog2(MAX_GROUPS + 1)) ?
                                  CFG_W : $clog2(MAX_GROUPS + 1);
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TILE_SIZE - 1);
  localparam logic [GCW-1:0]   GRP_MAX  = GCW'(MAX_GROUPS);

  logic [CFG_W-1:0]   groups_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [SUB_W-1:0]   sub_q, sub_d;
  logic [GRP_W-1:0]   grp_q, grp_d;
  logic [SUB_W-1:0]   phase_q, phase_d;
  logic [PIXEL_W-1:0] seg_q, seg_d;

  logic               out_valid_q, out_valid_d;
  logic [PIXEL_W-1:0] min_depth_q;
  logic [OUT_COL_W-1:0] out_col_q;
  logic               row_end_q;

  logic [GCW-1:0]     groups_ext, groups_eff;
  logic [CNT_W-1:0]   limit;
  logic [COL_W-1:0]   col_eff;
  logic [SUB_W-1:0]   sub_eff, phase_eff;
  logic [GRP_W-1:0]   grp_eff;
  logic [PIXEL_W-1:0] key, seg_new, merged, band_rdata;
  logic               accept, last_in_row, group_done, emit;

  // Row width in pixels, with the register clamped to 1..MAX_GROUPS.
  always_comb begin
    groups_ext = GCW'(groups_q);
    if (groups_ext == '0) begin
      groups_eff = GCW'(1);
    end else if (groups_ext > GRP_MAX) begin
      groups_eff = GRP_MAX;
    end else begin
      groups_eff = groups_ext;
    end
    limit = CNT_W'(groups_eff) * CNT_W'(TILE_SIZE);
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A frame start puts this pixel at column 0 of row 0.
  assign col_eff   = frame_start_i ? '0 : col_q;
  assign sub_eff   = frame_start_i ? '0 : sub_q;
  assign grp_eff   = frame_start_i ? '0 : grp_q;
  assign phase_eff = frame_start_i ? '0 : phase_q;

  // Invalid zero maps to the largest key, so a plain minimum skips it.
  assign key = depth_pixel_i - PIXEL_W'(1);

  always_comb begin
    last_in_row = (CNT_W'(col_eff) + CNT_W'(1)) >= limit;
    group_done  = (sub_eff == SUB_LAST);
    emit        = group_done && (phase_eff == SUB_LAST);

    if (sub_eff == '0) begin
      seg_new = key;
    end else begin
      seg_new = (key < seg_q) ? key : seg_q;
    end

    if (phase_eff == '0) begin
      merged = seg_new;
    end else begin
      merged = (band_rdata < seg_new) ? band_rdata : seg_new;
    end
  end

  always_comb begin
    col_d   = col_q;
    sub_d   = sub_q;
    grp_d   = grp_q;
    phase_d = phase_q;
    seg_d   = seg_q;
    if (accept) begin
      seg_d = seg_new;
      if (last_in_row) begin
        col_d   = '0;
        sub_d   = '0;
        grp_d   = '0;
        phase_d = (phase_eff == SUB_LAST) ? '0 : phase_eff + SUB_W'(1);
      end else begin
        col_d   = col_eff + COL_W'(1);
        sub_d   = group_done ? '0 : sub_eff + SUB_W'(1);
        grp_d   = group_done ? grp_eff + GRP_W'(1) : grp_eff;
        phase_d = phase_eff;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_q    <= GROUPS_RESET;
      col_q       <= '0;
      sub_q       <= '0;
      grp_q       <= '0;
      phase_q     <= '0;
      seg_q       <= KEY_INVALID;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        groups_q <= cfg_wdata_i;
      end
      col_q       <= col_d;
      sub_q       <= sub_d;
      grp_q       <= grp_d;
      phase_q     <= phase_d;
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      min_depth_q <= merged + PIXEL_W'(1);
      out_col_q   <= OUT_COL_W'(grp_eff);
      row_end_q   <= last_in_row;
    end
  end

  // The group's partial minimum is fetched on its first pixel and is held in
  // the read register until the group's last pixel merges with it.
  dmd_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (MAX_GROUPS)
  ) u_band_ram (
    .clk_i   (clk_i),
    .we_i    (accept && group_done),
    .waddr_i (grp_eff),
    .wdata_i (merged),
    .re_i    (accept && (sub_eff == '0)),
    .raddr_i (grp_eff),
    .rdata_o (band_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign min_depth_o  = min_depth_q;
  assign out_column_o = out_col_q;
  assign row_end_o    = row_end_q;

endmodule

/* hdl/dmd_checker.sv */
// ----------------------------------------------------------------------------
// dmd_checker
// Port-level checks of the depth minimum downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module dmd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [dmd_pkg::PIXEL_W-1:0]   depth_pixel_i,
  input logic                          frame_start_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [dmd_pkg::PIXEL_W-1:0]   min_depth_o,
  input logic [dmd_pkg::OUT_COL_W-1:0] out_column_o,
  input logic                          row_end_o
);

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(min_depth_o) && $stable(out_column_o) && $stable(row_end_o))
    else $error("result changed while stalled");

  // A waiting item keeps its payload until it is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(depth_pixel_i) && $stable(frame_start_i))
    else $error("input item changed while waiting");

  // With the output register empty the block must take a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // A result only follows an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without accepted item");

  // A taken result is not repeated when no new item arrives.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind depth_min_downsample_4x4 dmd_checker u_dmd_checker (.*);

/* tb/depth_min_downsample_4x4_tb.sv */
// ----------------------------------------------------------------------------
// depth_min_downsample_4x4_tb
// Streams depth frames through the 4x4 minimum pooler and checks every tile.
// A predictor keeps its own line store and counters, and works out each tile
// minimum as the pixels are accepted. The monitor compares each result, field
// by field, with the oldest prediction. Frames cover the reset row width, the
// narrowest rows and rows of up to twenty groups, leftover rows, broken frames,
// and rows narrowed mid-frame. The phases of the run mix source gaps and sink
// stalls in different ways; the first and last phases have neither.
// ----------------------------------------------------------------------------
module depth_min_downsample_4x4_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dmd_pkg::*;

  localparam int unsigned MAX_GROUPS    = 512;
  localparam int unsigned TILE_SIZE     = 4;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_LIMIT   = 10000;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_e;

  typedef enum logic [2:0] {
    PAT_DENSE,
    PAT_SPARSE,
    PAT_EDGE,
    PAT_NEAR,
    PAT_MIXED
  } pattern_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] depth;
    logic               frame_start;
  } pixel_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]   min_depth;
    logic [OUT_COL_W-1:0] column;
    logic                 row_end;
  } tile_result_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [PIXEL_W-1:0]   depth_pixel_i = '0;
  logic                 frame_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [PIXEL_W-1:0]   min_depth_o;
  logic [OUT_COL_W-1:0] out_column_o;
  logic                 row_end_o;

  pixel_item_t  pixel_q[$];
  tile_result_t tile_min_q[$];
  flow_e        flow_mode     = FLOW_FREE;
  logic         hold_go       = 1'b0;
  logic         hold_off      = 1'b0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;

  // Predictor state. Line store entries hold each partial minimum minus one,
  // so that an invalid zero pixel becomes the largest key.
  logic [PIXEL_W-1:0] band_key [MAX_GROUPS];
  logic [PIXEL_W-1:0] seg_key   = KEY_INVALID;
  logic [CFG_W-1:0]   groups_cfg = GROUPS_RESET;
  int unsigned        col_pos   = 0;
  int unsigned        row_phase = 0;

  depth_min_downsample_4x4 #(
    .MAX_GROUPS(MAX_GROUPS),
    .TILE_SIZE (TILE_SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .depth_pixel_i(depth_pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .min_depth_o  (min_depth_o),
    .out_column_o (out_column_o),
    .row_end_o    (row_end_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endfunction

  // Advances the predictor by one accepted pixel and queues the tile minimum
  // that the pixel completes, if any.
  function automatic void pool_pixel(logic [PIXEL_W-1:0] pixel, logic frame_start);
    int unsigned        groups;
    int unsigned        grp;
    int unsigned        sub;
    logic               row_last;
    logic [PIXEL_W-1:0] key;
    logic [PIXEL_W-1:0] merged;
    tile_result_t       res;
    if (groups_cfg == '0) begin
      groups = 1;
    end else if (groups_cfg > MAX_GROUPS) begin
      groups = MAX_GROUPS;
    end else begin
      groups = 32'(groups_cfg);
    end
    key = pixel - 1'b1;
    if (frame_start) begin
      col_pos   = 0;
      row_phase = 0;
      seg_key   = KEY_INVALID;
    end
    grp      = col_pos / TILE_SIZE;
    sub      = col_pos % TILE_SIZE;
    row_last = (col_pos + 1) >= groups * TILE_SIZE;
    if (sub == 0 || key < seg_key) begin
      seg_key = key;
    end
    if (sub == TILE_SIZE - 1 && grp < MAX_GROUPS) begin
      if (row_phase == 0 || seg_key < band_key[grp]) begin
        merged = seg_key;
      end else begin
        merged = band_key[grp];
      end
      band_key[grp] = merged;
      if (row_phase == TILE_SIZE - 1) begin
        res.min_depth = merged + 1'b1;
        res.column    = OUT_COL_W'(grp);
        res.row_end   = row_last;
        tile_min_q.push_back(res);
      end
    end
    if (row_last) begin
      col_pos   = 0;
      row_phase = (row_phase + 1) % TILE_SIZE;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic sender_gap();
    case (flow_mode)
      FLOW_SEND_GAPS: return $urandom_range(99) < 85;
      FLOW_BOTH:      return $urandom_range(99) < 31;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (flow_mode)
      FLOW_RECV_STALLS: return $urandom_range(99) < 85;
      FLOW_BOTH:        return $urandom_range(99) < 31;
      default:          return 1'b0;
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_depth(pattern_e pat);
    int unsigned r;
    r = $urandom_range(99);
    case (pat)
      PAT_DENSE: begin
        return (r < 10) ? '0 : PIXEL_W'($urandom);
      end
      PAT_SPARSE: begin
        if (r < 92) return '0;
        return (r < 96) ? 16'hFFFF : PIXEL_W'($urandom);
      end
      PAT_EDGE: begin
        case (r % 5)
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'hFFFF;
          3:       return 16'hFFFE;
          default: return 16'h8000;
        endcase
      end
      PAT_NEAR: begin
        return PIXEL_W'($urandom_range(0, 12));
      end
      default: begin
        return draw_depth(pattern_e'($urandom_range(0, 3)));
      end
    endcase
  endfunction

  function automatic int unsigned pick_groups();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 8);
    return $urandom_range(9, 20);
  endfunction

  // A register value of zero behaves as one group, so use it half the time.
  function automatic logic [CFG_W-1:0] cfg_for(int unsigned groups);
    if (groups == 1 && $urandom_range(1) == 1) return '0;
    return CFG_W'(groups);
  endfunction

  function automatic void push_pixel(logic [PIXEL_W-1:0] depth, logic frame_start);
    pixel_item_t px;
    px.depth       = depth;
    px.frame_start = frame_start;
    pixel_q.push_back(px);
  endfunction

  function automatic void queue_pixels(int unsigned count, pattern_e pat, logic start_frame);
    for (int unsigned i = 0; i < count; i++) begin
      push_pixel(draw_depth(pat), start_frame && i == 0);
    end
  endfunction

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i || tile_min_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_groups(logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    groups_cfg  = value;
    @(negedge clk_i);
  endtask

  // Source side: offers the next queued pixel and predicts on acceptance.
  always @(posedge clk_i) begin : pixel_source
    pixel_item_t next_px;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pool_pixel(depth_pixel_i, frame_start_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pixel_q.size() != 0 && !sender_gap()) begin
          next_px = pixel_q.pop_front();
          in_valid_i    <= 1'b1;
          depth_pixel_i <= next_px.depth;
          frame_start_i <= next_px.frame_start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: checks each accepted tile result against the oldest prediction.
  always @(posedge clk_i) begin : tile_sink
    tile_result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (tile_min_q.size() == 0) begin
          note_failure($sformatf("unexpected result: min_depth %0d out_column %0d row_end %0b",
                                 min_depth_o, out_column_o, row_end_o));
        end else begin
          want = tile_min_q.pop_front();
          if (min_depth_o !== want.min_depth) begin
            note_failure($sformatf("min_depth at column %0d: expected %0d, got %0d",
                                   want.column, want.min_depth, min_depth_o));
          end
          if (out_column_o !== want.column) begin
            note_failure($sformatf("out_column: expected %0d, got %0d",
                                   want.column, out_column_o));
          end
          if (row_end_o !== want.row_end) begin
            note_failure($sformatf("row_end at column %0d: expected %0b, got %0b",
                                   want.column, want.row_end, row_end_o));
          end
        end
      end
      out_ready_i <= !hold_off && !receiver_stall();
    end
  end

  // Long sink hold-off so that the output fills and the input backs up.
  initial begin : sink_hold
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("depth_min_downsample_4x4_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    flow_e       plan [5];
    int unsigned random_items;
    int unsigned groups;
    int unsigned narrow;
    int unsigned pending;
    int unsigned waited;
    plan = '{FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH, FLOW_FREE};
    for (int unsigned g = 0; g < MAX_GROUPS; g++) begin
      band_key[g] = KEY_INVALID;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One row at the reset row width and part of the next; the band is then
    // finished one group wide, so its tile shows where the first row ended.
    queue_pixels(4 * GROUPS_RESET + 37, PAT_MIXED, 1'b1);
    wait_drained();
    write_groups(CFG_W'(1));
    queue_pixels(9, PAT_MIXED, 1'b0);
    wait_drained();

    // One group per row: a tile whose only valid pixel is 0xFFFF, then a
    // leftover row and a frame restart that must produce nothing.
    write_groups('0);
    for (int unsigned i = 0; i < 16; i++) begin
      push_pixel((i == 15) ? 16'hFFFF : 16'h0000, i == 0);
    end
    push_pixel(16'h0001, 1'b0);
    push_pixel(16'h8000, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'h7FFF, 1'b0);
    push_pixel(16'h1234, 1'b1);
    push_pixel(16'hFFFE, 1'b0);
    push_pixel(16'h0002, 1'b0);
    push_pixel(16'h0000, 1'b0);
    wait_drained();

    write_groups(CFG_W'(1));
    hold_go = 1'b1;
    queue_pixels(64, PAT_DENSE, 1'b1);
    wait_drained();

    foreach (plan[p]) begin
      flow_mode    = plan[p];
      random_items = 0;
      while (random_items < RANDOM_ITEMS / 5) begin
        if ($urandom_range(99) < 12) begin
          // Narrow the rows in the middle of a frame. Narrowing only reads
          // line store entries that the band's first row already wrote.
          groups = $urandom_range(2, 8);
          write_groups(CFG_W'(groups));
          pending = $urandom_range(1, 16 * groups);
          queue_pixels(pending, PAT_MIXED, 1'b1);
          random_items += pending;
          wait_drained();
          narrow = $urandom_range(1, groups - 1);
          write_groups(cfg_for(narrow));
          pending = $urandom_range(1, 32 * narrow);
          queue_pixels(pending, PAT_MIXED, 1'b0);
          random_items += pending;
          wait_drained();
        end else begin
          groups = pick_groups();
          write_groups(cfg_for(groups));
          repeat ($urandom_range(1, 3)) begin
            if (random_items < RANDOM_ITEMS / 5) begin
              pending = $urandom_range(1, 2) * 16 * groups + $urandom_range(0, 12 * groups);
              if ($urandom_range(99) < 6) begin
                pending = $urandom_range(1, pending);
              end
              // Keep each phase near its share of the items.
              if (pending > RANDOM_ITEMS / 5 - random_items) begin
                pending = RANDOM_ITEMS / 5 - random_items;
              end
              queue_pixels(pending, pattern_e'($urandom_range(0, 4)), 1'b1);
              random_items += pending;
            end
          end
          wait_drained();
        end
      end
    end

    flow_mode = FLOW_FREE;
    do @(negedge clk_i);
    while (pixel_q.size() != 0 || in_valid_i);
    waited = 0;
    while (tile_min_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (tile_min_q.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", tile_min_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("depth_min_downsample_4x4_tb: PASS");
    end else begin
      $display("depth_min_downsample_4x4_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/dmd_pkg.sv
hdl/dmd_ram.sv
hdl/depth_min_downsample_4x4.sv
hdl/dmd_checker.sv
tb/depth_min_downsample_4x4_tb.sv
